// File: design/sbs_pkg.sv
package sbs_pkg;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int SIG_LEN_W    = 5;
    localparam int SIG_BYTES_HW = 16;
    localparam int OUT_OFFSET_W = 32;
    localparam int ALIGN_LOG2   = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VALUE_LO = 3'd0,
        REG_VALUE_HI = 3'd1,
        REG_MASK_LO  = 3'd2,
        REG_MASK_HI  = 3'd3,
        REG_LENGTH   = 3'd4,
        REG_ALIGN16  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [8*SIG_BYTES_HW-1:0] value;
        logic [8*SIG_BYTES_HW-1:0] mask;
        logic [SIG_LEN_W-1:0]      length;
        logic                      align16;
    } t_sig_cfg;

endpackage

// File: design/sbs_cfg.sv
module sbs_cfg
    import sbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_sig_cfg               o_cfg
);

    t_sig_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value   <= '0;
            r_cfg.mask    <= '0;
            r_cfg.length  <= SIG_LEN_W'(1);
            r_cfg.align16 <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VALUE_LO: r_cfg.value[63:0]    <= i_cfg_data;
                REG_VALUE_HI: r_cfg.value[127:64]  <= i_cfg_data;
                REG_MASK_LO:  r_cfg.mask[63:0]     <= i_cfg_data;
                REG_MASK_HI:  r_cfg.mask[127:64]   <= i_cfg_data;
                REG_LENGTH:   r_cfg.length         <= i_cfg_data[SIG_LEN_W-1:0];
                REG_ALIGN16:  r_cfg.align16        <= i_cfg_data[0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/sbs_match.sv
module sbs_match
    import sbs_pkg::*;
#(
    parameter int MAX_SIG_BYTES = 16
)
(
    input  t_sig_cfg                     i_cfg,
    input  logic [MAX_SIG_BYTES-1:0][7:0] i_window,
    output logic [SIG_LEN_W-1:0]         o_len,
    output logic                         o_hit
);

    localparam int IW = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES) : 1;

    logic [SIG_LEN_W-1:0] len;

    // clamp the programmed length into 1..MAX_SIG_BYTES
    always_comb begin
        if (i_cfg.length == '0) begin
            len = SIG_LEN_W'(1);
        end else if (i_cfg.length > SIG_LEN_W'(MAX_SIG_BYTES)) begin
            len = SIG_LEN_W'(MAX_SIG_BYTES);
        end else begin
            len = i_cfg.length;
        end
    end

    // signature byte i lines up with window entry len-1-i (entry 0 is newest)
    always_comb begin
        logic [SIG_LEN_W-1:0] diff;
        logic [IW-1:0]        idx;
        o_hit = 1'b1;
        diff  = '0;
        idx   = '0;
        for (int i = 0; i < MAX_SIG_BYTES; i++) begin
            if (SIG_LEN_W'(i) < len) begin
                diff = len - SIG_LEN_W'(i) - SIG_LEN_W'(1);
                idx  = diff[IW-1:0];
                if (((i_window[idx] ^ i_cfg.value[8*i +: 8]) & i_cfg.mask[8*i +: 8]) != 8'd0) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

    assign o_len = len;

endmodule

// File: design/masked_byte_signature_scanner.sv
// Channel    | Direction | Payload
// s_axis     | in        | tdata[7:0] data_byte, tlast last_byte
// m_axis     | out       | tdata[31:0] match_offset, tuser found
// cfg        | in        | index (register number), data (64-bit register value)
//
// One byte is taken per cycle while the result side is not stalled; a byte passes an
// input register, then the window compare and count update feed the result register.
// The masked 16-byte window compare and the offset counter add set the cycle.
// Synchronous active-low reset clears the region state and the valid bits of both stage
// registers, and resets the signature registers. A stalled result holds the input register,
// which then holds s_axis_tready low; configuration writes are always taken.
module masked_byte_signature_scanner
    import sbs_pkg::*;
#(
    parameter int MAX_SIG_BYTES = 16,
    parameter int OFFSET_BITS   = 32
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,  // [7:0] data_byte
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_OFFSET_W-1:0] m_axis_tdata,  // [31:0] match_offset
    output logic                    m_axis_tuser,  // [0] found
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = OFFSET_BITS + 1;

    t_sig_cfg cfg;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic [MAX_SIG_BYTES-1:0][7:0] r_window;
    logic [MAX_SIG_BYTES-1:0][7:0] n_window;
    logic [SW-1:0]                 r_seen;
    logic [SW-1:0]                 n_seen;
    logic                          r_reported;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [OUT_OFFSET_W-1:0] r_out_offset;

    logic                 advance;
    logic                 counting;
    logic [SIG_LEN_W-1:0] len;
    logic                 pattern_hit;
    logic [SW-1:0]        start;
    logic [SW+31:0]       start_ext;
    logic                 hit;
    logic                 miss;

    assign o_cfg_ready = 1'b1;

    sbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbs_match #(
        .MAX_SIG_BYTES (MAX_SIG_BYTES)
    ) u_match (
        .i_cfg    (cfg),
        .i_window (n_window),
        .o_len    (len),
        .o_hit    (pattern_hit)
    );

    // the held word moves on once the result slot is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_window[0] = r_in_byte;
        for (int k = 1; k < MAX_SIG_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign counting  = !r_seen[OFFSET_BITS];
    assign n_seen    = r_seen + SW'(1);
    assign start     = n_seen - SW'(len);
    assign start_ext = {32'd0, start};

    assign hit  = !r_reported && counting && (n_seen >= SW'(len))
                  && (!cfg.align16 || (start[ALIGN_LOG2-1:0] == '0)) && pattern_hit;
    assign miss = r_in_last && !r_reported && !hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_window   <= '0;
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_window <= n_window;
                if (counting) begin
                    r_seen <= n_seen;
                end
                r_reported <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && (hit || miss)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && (hit || miss)) begin
            r_out_found  <= hit;
            r_out_offset <= hit ? start_ext[OUT_OFFSET_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

`ifndef SYNTHESIS
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result with non-zero offset");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> ((r_seen == '0) && !r_reported))
        else $error("region state not cleared after last word");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen[OFFSET_BITS] |-> (r_seen[OFFSET_BITS-1:0] == '0))
        else $error("byte count passed saturation");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_last)))
        else $error("held input word changed while stalled");
`endif

endmodule

// File: tb/scan_checker.sv
`timescale 1ns / 100ps

module scan_checker
    import sbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [7:0]              i_s_tdata,
    input  logic                    i_s_tlast,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_OFFSET_W-1:0] i_m_tdata,
    input  logic                    i_m_tuser,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    localparam logic [32:0] COUNT_CAP = 33'd1 << 32;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
    } t_scan_verdict;

    t_scan_verdict verdict_q[$];
    t_scan_verdict want;
    t_sig_cfg      sig;
    logic [7:0]    window [SIG_BYTES_HW];
    logic [32:0]   seen_cnt;
    logic          hit_taken;
    int            mismatches;

    function void clear_region();
        int k;
        for (k = 0; k < SIG_BYTES_HW; k++) window[k] = 8'h00;
        seen_cnt  = '0;
        hit_taken = 1'b0;
    endfunction

    // Work out the verdict, if any, that one byte of the region gives.
    function void scan_byte(input logic [7:0] b, input logic last);
        int          len;
        int          k;
        logic [32:0] start;
        logic        hit;
        if (sig.length == 0)
            len = 1;
        else if (sig.length > SIG_BYTES_HW)
            len = SIG_BYTES_HW;
        else
            len = int'(sig.length);
        if (!hit_taken) begin
            for (k = SIG_BYTES_HW - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            // a saturated count stops any further match in this region
            if (seen_cnt < COUNT_CAP) begin
                seen_cnt = seen_cnt + 1;
                if (seen_cnt >= len) begin
                    start = seen_cnt - len;
                    hit = !sig.align16 || (start[ALIGN_LOG2-1:0] == '0);
                    // signature byte 0 lines up with the oldest byte of the span
                    for (k = 0; k < len; k++) begin
                        if (((window[len-1-k] ^ sig.value[8*k +: 8]) & sig.mask[8*k +: 8]) != 0)
                            hit = 1'b0;
                    end
                    if (hit) begin
                        hit_taken = 1'b1;
                        verdict_q.push_back('{1'b1, start[OUT_OFFSET_W-1:0]});
                    end
                end
            end
        end
        if (last) begin
            if (!hit_taken) verdict_q.push_back('{1'b0, '0});
            clear_region();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sig = '0;
            sig.length = 1;
            clear_region();
            verdict_q.delete();
            mismatches = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result word: found %0d match_offset %0d",
                           i_m_tuser, i_m_tdata);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tuser !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_m_tuser);
                        mismatches++;
                    end
                    if (i_m_tdata !== want.offset) begin
                        $error("match_offset: expected %0d, got %0d", want.offset, i_m_tdata);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) scan_byte(i_s_tdata, i_s_tlast);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_VALUE_LO: sig.value[63:0]   = i_cfg_data;
                    REG_VALUE_HI: sig.value[127:64] = i_cfg_data;
                    REG_MASK_LO:  sig.mask[63:0]    = i_cfg_data;
                    REG_MASK_HI:  sig.mask[127:64]  = i_cfg_data;
                    REG_LENGTH:   sig.length        = i_cfg_data[SIG_LEN_W-1:0];
                    REG_ALIGN16:  sig.align16       = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= verdict_q.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb
    import sbs_pkg::*;
;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_B = 3'd7;
    localparam int                     TARGET_BYTES   = 1300;
    localparam int                     LONG_STALL     = 300;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SLUGGISH, RX_PERIODIC} t_rx_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_OFFSET_W-1:0] m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    int         mismatches;
    int         outstanding;
    logic [7:0] region[$];
    int         sent_bytes = 0;
    int         burst_left = 0;
    int         stall_token = 0;
    int         stall_seen = 0;
    int         stall_left = 0;
    int         rx_left = 0;
    int         pat_cnt = 0;
    t_rx_mode   rx_mode = RX_ALWAYS;
    int         phase;

    masked_byte_signature_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scan_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: a long hold when asked, otherwise a changing stall pattern.
    always @(posedge i_clk) begin
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = LONG_STALL;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            pat_cnt++;
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SLUGGISH: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ((pat_cnt % 5) < 3);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_region();
        foreach (region[i]) send_byte(region[i], i == region.size() - 1);
    endtask

    // Hold the sender until every verdict is back, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_sig(input logic [127:0] val, input logic [127:0] msk,
                               input logic [4:0] len, input logic align, input logic poke);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_VALUE_LO, val[63:0]);
        write_reg(REG_VALUE_HI, val[127:64]);
        if (poke) write_reg(REG_UNMAPPED_A, junk);
        write_reg(REG_MASK_LO, msk[63:0]);
        write_reg(REG_MASK_HI, msk[127:64]);
        // upper bits of the length and align words must be dropped
        write_reg(REG_LENGTH, {junk[63:5], len});
        write_reg(REG_ALIGN16, {junk[63:1], align});
        if (poke) write_reg(REG_UNMAPPED_B, ~junk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic squeeze);
        logic [127:0] val;
        logic [127:0] msk;
        logic [4:0]   len_code;
        logic         align;
        int           elen;
        int           kind;
        int           start;
        int           rlen;
        int           i;
        int           bit_i;
        val = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       msk = '0;
            1, 2:    msk = '1;
            3:       msk = {$urandom, $urandom, $urandom, $urandom};
            4:       msk = {$urandom, $urandom, $urandom, $urandom}
                         & {$urandom, $urandom, $urandom, $urandom};
            default: msk = {$urandom, $urandom, $urandom, $urandom}
                         | {$urandom, $urandom, $urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0:       len_code = 5'd1;
            1:       len_code = 5'd16;
            2:       len_code = 5'd0;
            3:       len_code = 5'($urandom_range(17, 31));
            default: len_code = 5'($urandom_range(1, 16));
        endcase
        elen  = (len_code == 0) ? 1 : (len_code > SIG_BYTES_HW) ? SIG_BYTES_HW : int'(len_code);
        align = 1'($urandom_range(0, 1));
        program_sig(val, msk, len_code, align, $urandom_range(0, 3) == 0);

        if (squeeze) begin
            // one-byte regions each give a verdict, so a held result side backs up
            stall_token <= stall_token + 1;
            repeat (24) begin
                region = {8'($urandom)};
                send_region();
            end
        end

        repeat ($urandom_range(4, 12)) begin
            region.delete();
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
                rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100)
                                                   : $urandom_range(1, 24);
                repeat (rlen) region.push_back(8'($urandom));
            end else begin
                start = (align && $urandom_range(0, 3) != 0) ? 16 * $urandom_range(0, 3)
                                                             : $urandom_range(0, 40);
                rlen = start + elen + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
                repeat (rlen) region.push_back(8'($urandom));
                for (i = 0; i < elen; i++)
                    region[start+i] = val[8*i +: 8] ^ (8'($urandom) & ~msk[8*i +: 8]);
                // break the embedded copy on one cared-for bit
                if (kind >= 6) begin
                    i = $urandom_range(0, elen - 1);
                    if (msk[8*i +: 8] != 0) begin
                        do bit_i = $urandom_range(0, 7); while (!msk[8*i + bit_i]);
                        region[start+i] = region[start+i] ^ (8'd1 << bit_i);
                    end
                end
            end
            send_region();
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset signature: one byte, nothing cared for, so every region hits at 0
        region = {8'hFF};
        send_region();
        region = {8'h00, 8'h12};
        send_region();
        drain();

        // length 0 acts as 1; writes to unmapped indexes leave the signature alone
        program_sig(128'hA5, 128'hFF, 5'd0, 1'b0, 1'b1);
        region = {8'h00, 8'h5A, 8'hA5};
        send_region();
        region = {8'h11};
        send_region();
        drain();

        // oversized length clamps to sixteen; a short region finds nothing
        program_sig({$urandom, $urandom, $urandom, $urandom}, '1, 5'd31, 1'b0, 1'b0);
        region = {8'h00, 8'hFF, 8'h80};
        send_region();
        drain();

        // aligned mode: reject a hit at offset 1, take one at 0 on the last byte
        program_sig(128'h0201, 128'hFFFF, 5'd2, 1'b1, 1'b0);
        region = {8'h00, 8'h01, 8'h02};
        send_region();
        region = {8'h01, 8'h02};
        send_region();
        drain();

        phase = 0;
        while (sent_bytes < TARGET_BYTES) begin
            random_phase(phase == 2);
            phase++;
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
design/sbs_pkg.sv
design/sbs_cfg.sv
design/sbs_match.sv
design/masked_byte_signature_scanner.sv
tb/scan_checker.sv
tb/tb.sv
